// ===== rtl/tdrs_pkg.sv =====
// ============================================================================
// tdrs_pkg
// Shared types, widths and constants of the downlink timer and radar
// serializer core.
// ============================================================================
package tdrs_pkg;

    // ------------------------------------------------------------------------
    // Field widths
    // ------------------------------------------------------------------------
    localparam int PERIOD_W = 20;
    localparam int DATA_W   = 15;
    localparam int PULSE_W  = 32;
    localparam int CHAN_W   = 16;
    localparam int REQ_W    = 2;

    // ------------------------------------------------------------------------
    // Serializer sizing
    // ------------------------------------------------------------------------
    localparam int BIT_SLOT_PULSES = 160;
    localparam int FRAME_BITS      = 16;
    localparam int CNT_W           = $clog2(FRAME_BITS + 1);

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] REG_DOWNLINK_PERIOD = CFG_IDX_W'(0);

    // ------------------------------------------------------------------------
    // Item kinds and count request codes
    // ------------------------------------------------------------------------
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        CNT_NONE = 2'd0,
        CNT_UP   = 2'd1,
        CNT_DOWN = 2'd2
    } t_count_req;

    // ------------------------------------------------------------------------
    // Bit slot test: pulse is a multiple of 2**SLOT_SHIFT * SLOT_ODD when its
    // low bits are clear and (pulse >> SLOT_SHIFT) * inverse(SLOT_ODD), taken
    // modulo 2**32, does not exceed (2**32 - 1) / SLOT_ODD.
    // ------------------------------------------------------------------------
    function automatic int trailing_zeros(input int unsigned v);
        int n;
        n = 0;
        while ((v[0] == 1'b0) && (n < 31)) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    function automatic logic [31:0] odd_inverse(input logic [31:0] d);
        logic [31:0] x;
        x = d;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - d * x);
        end
        return x;
    endfunction

    localparam int          SLOT_SHIFT = trailing_zeros(BIT_SLOT_PULSES);
    localparam int          SLOT_ODD   = BIT_SLOT_PULSES >> SLOT_SHIFT;
    localparam logic [31:0] SLOT_MASK  = 32'((64'd1 << SLOT_SHIFT) - 64'd1);
    localparam logic [31:0] SLOT_INV   = odd_inverse(32'(SLOT_ODD));
    localparam logic [31:0] SLOT_LIMIT = 32'(64'hFFFF_FFFF / SLOT_ODD);

    // ------------------------------------------------------------------------
    // Inter-module bundles
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic fire;
        logic send;
    } t_step;

    typedef struct packed {
        logic                we;
        logic [PERIOD_W-1:0] period;
    } t_cfg_wr;

    typedef struct packed {
        logic              irq;
        logic [CHAN_W-1:0] word_34;
        logic [CHAN_W-1:0] word_35;
    } t_dl_res;

    typedef struct packed {
        t_count_req request;
        logic       refused;
        logic       busy;
    } t_rdr_res;

endpackage

// ===== rtl/tdrs_timer.sv =====
// ============================================================================
// tdrs_timer
// Downlink word timer: counts ticks down from the period and latches the two
// downlink channel values each time the countdown runs out.
// ============================================================================
module tdrs_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdrs_pkg::t_step               i_step,
    input  tdrs_pkg::t_cfg_wr             i_cfg,
    input  logic [tdrs_pkg::CHAN_W-1:0]   i_channel_34_value,
    input  logic [tdrs_pkg::CHAN_W-1:0]   i_channel_35_value,
    output logic [tdrs_pkg::PERIOD_W-1:0] o_period,
    output tdrs_pkg::t_dl_res             o_res
);
    import tdrs_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_countdown;
    logic [CHAN_W-1:0]   r_word_34;
    logic [CHAN_W-1:0]   r_word_35;

    logic [PERIOD_W-1:0] w_dec;
    logic                w_run;
    logic                w_take;

    // Decrement, saturating at zero; a word is taken when the count lands on zero
    assign w_dec  = (r_countdown != '0) ? (r_countdown - PERIOD_W'(1)) : '0;
    assign w_run  = (i_step.send == REQ_TICK) && (r_period != '0);
    assign w_take = w_run && (w_dec == '0);

    // Result of this item: words as they stand after the item
    always_comb begin
        o_res.irq     = w_take;
        o_res.word_34 = w_take ? i_channel_34_value : r_word_34;
        o_res.word_35 = w_take ? i_channel_35_value : r_word_35;
    end

    assign o_period = r_period;

    // Hold period and countdown; reload on a register write or a taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_countdown <= '0;
            r_word_34   <= '0;
            r_word_35   <= '0;
        end else if (i_cfg.we) begin
            r_period    <= i_cfg.period;
            r_countdown <= i_cfg.period;
        end else if (i_step.fire && w_run) begin
            if (w_take) begin
                r_countdown <= r_period;
                r_word_34   <= i_channel_34_value;
                r_word_35   <= i_channel_35_value;
            end else begin
                r_countdown <= w_dec;
            end
        end
    end

endmodule

// ===== rtl/tdrs_serializer.sv =====
// ============================================================================
// tdrs_serializer
// Radar bit serializer: shifts a frame out MSB first, one count request per
// bit slot, and keeps a refused bit for the next slot.
// ============================================================================
module tdrs_serializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tdrs_pkg::t_step              i_step,
    input  logic [tdrs_pkg::DATA_W-1:0]  i_radar_data,
    input  logic [tdrs_pkg::PULSE_W-1:0] i_timepulse_count,
    input  logic                         i_radar_counter_free,
    output tdrs_pkg::t_rdr_res           o_res
);
    import tdrs_pkg::*;

    localparam logic [FRAME_BITS-1:0] LEAD = {1'b1, {(FRAME_BITS-1){1'b0}}};

    logic [FRAME_BITS-1:0] r_frame;
    logic [CNT_W-1:0]      r_bits_left;

    logic [FRAME_BITS-1:0] n_frame;
    logic [CNT_W-1:0]      n_bits_left;

    logic [31:0] w_odd_part;
    logic [31:0] w_prod;
    logic        w_slot;
    logic        w_offer;
    logic        w_shift;

    // Bit slot test by multiplication with the inverse of the odd factor
    assign w_odd_part = 32'(i_timepulse_count) >> SLOT_SHIFT;
    assign w_prod     = w_odd_part * SLOT_INV;
    assign w_slot     = ((32'(i_timepulse_count) & SLOT_MASK) == '0) && (w_prod <= SLOT_LIMIT);

    assign w_offer = (i_step.send == REQ_TICK) && (r_bits_left != '0) && w_slot;
    assign w_shift = w_offer && i_radar_counter_free;

    // Next frame state: load on a send, advance on an accepted bit
    always_comb begin
        n_frame     = r_frame;
        n_bits_left = r_bits_left;
        if (i_step.send == REQ_SEND) begin
            n_frame     = FRAME_BITS'(i_radar_data) | LEAD;
            n_bits_left = CNT_W'(FRAME_BITS);
        end else if (w_shift) begin
            n_frame     = r_frame << 1;
            n_bits_left = r_bits_left - CNT_W'(1);
        end
    end

    // Result of this item
    always_comb begin
        o_res.request = CNT_NONE;
        if (w_shift) begin
            o_res.request = r_frame[FRAME_BITS-1] ? CNT_UP : CNT_DOWN;
        end
        o_res.refused = w_offer && !i_radar_counter_free;
        o_res.busy    = (n_bits_left != '0);
    end

    // Hold frame and bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_bits_left <= '0;
        end else if (i_step.fire) begin
            r_frame     <= n_frame;
            r_bits_left <= n_bits_left;
        end
    end

endmodule

// ===== rtl/telemetry_downlink_and_radar_serializer_core.sv =====
// ============================================================================
// telemetry_downlink_and_radar_serializer_core
// Downlink word timer and radar bit serializer driven by timepulse ticks and
// radar word sends.
// ============================================================================
// One item per clock cycle, sustained: every accepted item is held in an input
// register, processed through the timer and serializer logic, and its result
// is loaded into an output register when the output register is free or
// being taken. The only throttle is backpressure from the output: the input
// register empties as soon as the output register is free or being taken.
// The longest path runs through the 32-bit bit slot multiplier in the
// serializer. There is no clearing pass; the block accepts items as soon as
// reset is released.
// Write the downlink period only while no item is in flight.
module telemetry_downlink_and_radar_serializer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdrs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tdrs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tdrs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [tdrs_pkg::DATA_W-1:0]     i_radar_data,
    input  logic [tdrs_pkg::PULSE_W-1:0]    i_timepulse_count,
    input  logic                            i_radar_counter_free,
    input  logic [tdrs_pkg::CHAN_W-1:0]     i_channel_34_value,
    input  logic [tdrs_pkg::CHAN_W-1:0]     i_channel_35_value,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_downlink_interrupt,
    output logic [tdrs_pkg::CHAN_W-1:0]     o_downlink_word_34,
    output logic [tdrs_pkg::CHAN_W-1:0]     o_downlink_word_35,
    output logic [tdrs_pkg::REQ_W-1:0]      o_radar_count_request,
    output logic                            o_radar_refused,
    output logic                            o_radar_busy
);
    import tdrs_pkg::*;

    // Input register
    logic                r_in_valid;
    logic                r_req_type;
    logic [DATA_W-1:0]   r_radar_data;
    logic [PULSE_W-1:0]  r_timepulse_count;
    logic                r_radar_counter_free;
    logic [CHAN_W-1:0]   r_channel_34_value;
    logic [CHAN_W-1:0]   r_channel_35_value;

    // Output register
    logic                r_out_valid;
    logic                r_irq;
    logic [CHAN_W-1:0]   r_word_34;
    logic [CHAN_W-1:0]   r_word_35;
    t_count_req          r_request;
    logic                r_refused;
    logic                r_busy;

    logic                w_in_xfer;
    logic                w_fire;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic [PERIOD_W-1:0] w_period;
    t_step               w_step;
    t_cfg_wr             w_cfg;
    t_dl_res             w_dl_res;
    t_rdr_res            w_rdr_res;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_cfg.we  = psel && penable && pwrite && pready &&
                       (w_cfg_idx == REG_DOWNLINK_PERIOD);
    assign w_cfg.period = pwdata[PERIOD_W-1:0];

    always_comb begin
        prdata = '0;
        if (w_cfg_idx == REG_DOWNLINK_PERIOD) begin
            prdata = CFG_DATA_W'(w_period);
        end
    end

    // ------------------------------------------------------------------------
    // Handshake: process the held item whenever the output slot frees up
    // ------------------------------------------------------------------------
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_step.fire = w_fire;
    assign w_step.send = r_req_type;

    // Capture the item on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_type           <= i_req_type;
            r_radar_data         <= i_radar_data;
            r_timepulse_count    <= i_timepulse_count;
            r_radar_counter_free <= i_radar_counter_free;
            r_channel_34_value   <= i_channel_34_value;
            r_channel_35_value   <= i_channel_35_value;
        end
    end

    // ------------------------------------------------------------------------
    // Processing units
    // ------------------------------------------------------------------------
    tdrs_timer u_timer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_step),
        .i_cfg              (w_cfg),
        .i_channel_34_value (r_channel_34_value),
        .i_channel_35_value (r_channel_35_value),
        .o_period           (w_period),
        .o_res              (w_dl_res)
    );

    tdrs_serializer u_serializer (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (w_step),
        .i_radar_data         (r_radar_data),
        .i_timepulse_count    (r_timepulse_count),
        .i_radar_counter_free (r_radar_counter_free),
        .o_res                (w_rdr_res)
    );

    // ------------------------------------------------------------------------
    // Result register: load on fire, drop after the transfer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_irq     <= w_dl_res.irq;
            r_word_34 <= w_dl_res.word_34;
            r_word_35 <= w_dl_res.word_35;
            r_request <= w_rdr_res.request;
            r_refused <= w_rdr_res.refused;
            r_busy    <= w_rdr_res.busy;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_downlink_interrupt  = r_irq;
    assign o_downlink_word_34    = r_word_34;
    assign o_downlink_word_35    = r_word_35;
    assign o_radar_count_request = r_request;
    assign o_radar_refused       = r_refused;
    assign o_radar_busy          = r_busy;

endmodule

// ===== rtl/tdrs_checker.sv =====
// ============================================================================
// tdrs_checker
// Port-level checks of the downlink timer and radar serializer core.
// ============================================================================
module tdrs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [tdrs_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [tdrs_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [tdrs_pkg::CFG_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            i_req_type,
    input logic [tdrs_pkg::DATA_W-1:0]     i_radar_data,
    input logic [tdrs_pkg::PULSE_W-1:0]    i_timepulse_count,
    input logic                            i_radar_counter_free,
    input logic [tdrs_pkg::CHAN_W-1:0]     i_channel_34_value,
    input logic [tdrs_pkg::CHAN_W-1:0]     i_channel_35_value,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_downlink_interrupt,
    input logic [tdrs_pkg::CHAN_W-1:0]     o_downlink_word_34,
    input logic [tdrs_pkg::CHAN_W-1:0]     o_downlink_word_35,
    input logic [tdrs_pkg::REQ_W-1:0]      o_radar_count_request,
    input logic                            o_radar_refused,
    input logic                            o_radar_busy
);
    import tdrs_pkg::*;

    // No result is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // A refused slot carries no count request, and the unused request code never appears
    a_refuse_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_radar_refused || (o_radar_count_request == CNT_NONE)) &&
                        ((o_radar_count_request == CNT_NONE) ||
                         (o_radar_count_request == CNT_UP) ||
                         (o_radar_count_request == CNT_DOWN)))
        else $error("bad radar request combination");

    // Hold a stalled result's word 34, count request and interrupt unchanged until its transfer
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable(o_downlink_word_34) && $stable(o_radar_count_request) &&
            $stable(o_downlink_interrupt))
        else $error("stalled result changed");

endmodule

bind telemetry_downlink_and_radar_serializer_core tdrs_checker u_tdrs_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Downlink timer and radar serializer core testbench
// Drives timepulse ticks and radar word sends over the input valid/ready
// channel, keeps a cycle-free model of the downlink countdown and the radar
// frame shifter, and compares every output transfer field by field against
// the oldest predicted result. Both channels idle and stall at random, and
// the downlink period is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tdrs_pkg::*;

    localparam int          CLK_HALF        = 10;
    localparam int          RESET_CYCLES    = 7;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int          HOLD_OFF_CYCLES = 150;
    localparam int          PHASE_ITEMS     = 200;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int unsigned SLOT_K_MAX      = 32'hFFFF_FFFF / BIT_SLOT_PULSES;
    localparam logic [PULSE_W-1:0]  TOP_SLOT   = 32'(SLOT_K_MAX * BIT_SLOT_PULSES);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(1);

    typedef struct packed {
        logic              irq;
        logic [CHAN_W-1:0] word_34;
        logic [CHAN_W-1:0] word_35;
        t_count_req        request;
        logic              refused;
        logic              busy;
    } downlink_radar_result_t;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_req_type;
    logic [DATA_W-1:0]     i_radar_data;
    logic [PULSE_W-1:0]    i_timepulse_count;
    logic                  i_radar_counter_free;
    logic [CHAN_W-1:0]     i_channel_34_value;
    logic [CHAN_W-1:0]     i_channel_35_value;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_downlink_interrupt;
    logic [CHAN_W-1:0]     o_downlink_word_34;
    logic [CHAN_W-1:0]     o_downlink_word_35;
    logic [REQ_W-1:0]      o_radar_count_request;
    logic                  o_radar_refused;
    logic                  o_radar_busy;

    // Model state of the timer and the serializer
    logic [PERIOD_W-1:0]   model_period;
    logic [PERIOD_W-1:0]   model_countdown;
    logic [CHAN_W-1:0]     model_word_34;
    logic [CHAN_W-1:0]     model_word_35;
    logic [FRAME_BITS-1:0] model_frame;
    logic [CNT_W-1:0]      model_bits_left;

    downlink_radar_result_t due_results[$];
    int                     error_count;
    int                     cycle_count;
    int                     hold_off_count;
    logic                   tx_idle_en;
    logic                   rx_idle_en;

    telemetry_downlink_and_radar_serializer_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_req_type           (i_req_type),
        .i_radar_data         (i_radar_data),
        .i_timepulse_count    (i_timepulse_count),
        .i_radar_counter_free (i_radar_counter_free),
        .i_channel_34_value   (i_channel_34_value),
        .i_channel_35_value   (i_channel_35_value),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_downlink_interrupt (o_downlink_interrupt),
        .o_downlink_word_34   (o_downlink_word_34),
        .o_downlink_word_35   (o_downlink_word_35),
        .o_radar_count_request(o_radar_count_request),
        .o_radar_refused      (o_radar_refused),
        .o_radar_busy         (o_radar_busy)
    );

    // Generate the clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Advance the model by one accepted item and return its result
    function automatic downlink_radar_result_t step_downlink_radar(
        input logic               req,
        input logic [DATA_W-1:0]  data,
        input logic [PULSE_W-1:0] pulse,
        input logic               counter_free,
        input logic [CHAN_W-1:0]  chan_34,
        input logic [CHAN_W-1:0]  chan_35
    );
        downlink_radar_result_t res;
        res.irq     = 1'b0;
        res.request = CNT_NONE;
        res.refused = 1'b0;
        if (req == REQ_SEND) begin
            // Load a fresh frame behind a leading one, dropping any frame in progress
            model_frame     = {1'b1, data};
            model_bits_left = CNT_W'(FRAME_BITS);
        end else begin
            // Count down, latch the channels and reload on zero
            if (model_period != '0) begin
                if (model_countdown != '0)
                    model_countdown = model_countdown - 1'b1;
                if (model_countdown == '0) begin
                    model_word_34   = chan_34;
                    model_word_35   = chan_35;
                    res.irq         = 1'b1;
                    model_countdown = model_period;
                end
            end
            // Shift out the next bit on a slot, or hold it when the counter is busy
            if (model_bits_left != '0 && (pulse % 32'(BIT_SLOT_PULSES)) == 0) begin
                if (!counter_free) begin
                    res.refused = 1'b1;
                end else begin
                    res.request     = model_frame[model_bits_left - 1] ? CNT_UP : CNT_DOWN;
                    model_bits_left = model_bits_left - 1'b1;
                end
            end
        end
        res.word_34 = model_word_34;
        res.word_35 = model_word_35;
        res.busy    = (model_bits_left != '0);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    // Compare each output transfer against the oldest prediction
    always @(posedge i_clk) begin : result_check
        downlink_radar_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = due_results.pop_front();
                check_field("downlink_interrupt", o_downlink_interrupt, want.irq);
                check_field("downlink_word_34", o_downlink_word_34, want.word_34);
                check_field("downlink_word_35", o_downlink_word_35, want.word_35);
                check_field("radar_count_request", o_radar_count_request, want.request);
                check_field("radar_refused", o_radar_refused, want.refused);
                check_field("radar_busy", o_radar_busy, want.busy);
            end
        end
    end

    // Drive the output ready: random stalls, plus long hold-offs on request
    initial begin : out_ready_drive
        int stall_left;
        int hold_off_seen;
        int roll;
        stall_left    = 0;
        hold_off_seen = 0;
        i_out_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_seen != hold_off_count) begin
                hold_off_seen = hold_off_count;
                stall_left    = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!rx_idle_en) begin
                i_out_ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    i_out_ready <= 1'b1;
                end else begin
                    stall_left  = (roll < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    // Offer one item, hold it until the transfer, then predict its result
    task automatic send_item(input logic               req,
                             input logic [DATA_W-1:0]  data,
                             input logic [PULSE_W-1:0] pulse,
                             input logic               counter_free,
                             input logic [CHAN_W-1:0]  chan_34,
                             input logic [CHAN_W-1:0]  chan_35);
        int gap;
        int roll;
        gap = 0;
        if (tx_idle_en) begin
            roll = $urandom_range(0, 99);
            if (roll >= 97)
                gap = $urandom_range(15, 40);
            else if (roll >= 75)
                gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_req_type           <= req;
        i_radar_data         <= data;
        i_timepulse_count    <= pulse;
        i_radar_counter_free <= counter_free;
        i_channel_34_value   <= chan_34;
        i_channel_35_value   <= chan_35;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        due_results.push_back(step_downlink_radar(req, data, pulse, counter_free,
                                                  chan_34, chan_35));
    endtask

    task automatic send_random_item();
        logic [PULSE_W-1:0] pulse;
        logic               req;
        // Mostly slot ticks so frames run to the end; sends are rare
        if ($urandom_range(0, 99) < 70)
            pulse = 32'($urandom_range(0, SLOT_K_MAX) * BIT_SLOT_PULSES);
        else
            pulse = $urandom();
        req = ($urandom_range(0, 99) < 3) ? REQ_SEND : REQ_TICK;
        send_item(req, DATA_W'($urandom()), pulse, $urandom_range(0, 99) < 85,
                  CHAN_W'($urandom()), CHAN_W'($urandom()));
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register with setup and access phases while the core is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (index == REG_DOWNLINK_PERIOD) begin
            model_period    = value[PERIOD_W-1:0];
            model_countdown = value[PERIOD_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Ticks with no frame loaded and the timer off
    task automatic test_idle_ticks();
        send_item(REQ_TICK, '1, '0, 1'b1, '1, '1);
        send_item(REQ_TICK, '1, '1, 1'b0, '0, '0);
        send_item(REQ_TICK, '0, 32'(BIT_SLOT_PULSES), 1'b1, '1, '0);
        drain_results();
    endtask

    // One frame with refusals, a non-slot tick and a replacing send
    task automatic test_radar_frame();
        send_item(REQ_SEND, '0, '1, 1'b0, '0, '0);
        send_item(REQ_TICK, '1, '0, 1'b0, '0, '0);
        send_item(REQ_TICK, '0, TOP_SLOT, 1'b1, '0, '0);
        send_item(REQ_TICK, '0, 32'(BIT_SLOT_PULSES), 1'b1, '0, '0);
        send_item(REQ_TICK, '0, '1, 1'b1, '0, '0);
        send_item(REQ_SEND, '1, '0, 1'b1, '1, '1);
        send_item(REQ_TICK, '0, 32'(2 * BIT_SLOT_PULSES), 1'b1, '0, '0);
        send_item(REQ_TICK, '0, 32'(3 * BIT_SLOT_PULSES), 1'b0, '0, '0);
        send_item(REQ_TICK, '0, 32'(4 * BIT_SLOT_PULSES), 1'b1, '0, '0);
        drain_results();
    endtask

    // Downlink timer at period one, a small period, an unused index, max and zero
    task automatic test_downlink_timer();
        write_register(REG_DOWNLINK_PERIOD, 32'd1);
        send_item(REQ_TICK, '0, 32'd1, 1'b1, '1, '0);
        send_item(REQ_TICK, '0, 32'd2, 1'b1, '0, '1);
        write_register(REG_DOWNLINK_PERIOD, 32'hFFF0_0003);
        send_item(REQ_TICK, '0, 32'd3, 1'b1, 16'h1234, 16'h5678);
        send_item(REQ_SEND, 15'h2AAA, 32'd4, 1'b1, '0, '0);
        send_item(REQ_TICK, '0, 32'd5, 1'b1, 16'hABCD, 16'hEF01);
        send_item(REQ_TICK, '0, 32'd6, 1'b1, '1, '1);
        write_register(REG_UNUSED, '1);
        send_item(REQ_TICK, '0, 32'd7, 1'b1, '0, '0);
        write_register(REG_DOWNLINK_PERIOD, '1);
        send_item(REQ_TICK, '0, 32'd8, 1'b1, '1, '1);
        write_register(REG_DOWNLINK_PERIOD, '0);
        send_item(REQ_TICK, '0, 32'd9, 1'b1, '1, '1);
        drain_results();
    endtask

    // Hold the output off while items keep coming, then pause the sender
    task automatic test_backpressure();
        write_register(REG_DOWNLINK_PERIOD, 32'd5);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        hold_off_count++;
        repeat (40) send_random_item();
        drain_results();
        tx_idle_en = 1'b1;
        repeat (20) send_random_item();
        drain_results();
    endtask

    // Random traffic over several downlink periods
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] cfg;
        for (int phase = 0; phase < 6; phase++) begin
            cfg = $urandom();
            case (phase)
                0: cfg[PERIOD_W-1:0] = '0;
                1: cfg[PERIOD_W-1:0] = PERIOD_W'(1);
                2: cfg[PERIOD_W-1:0] = PERIOD_W'(2);
                3: cfg[PERIOD_W-1:0] = PERIOD_W'(7);
                4: cfg[PERIOD_W-1:0] = PERIOD_W'($urandom_range(3, 60));
                default: cfg[PERIOD_W-1:0] = PERIOD_MAX;
            endcase
            write_register(REG_DOWNLINK_PERIOD, cfg);
            tx_idle_en = phase[0];
            rx_idle_en = ~phase[1];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Flip idling now and then so busy stretches alternate with gaps
                if ($urandom_range(0, 59) == 0)
                    tx_idle_en = ~tx_idle_en;
                if ($urandom_range(0, 59) == 0)
                    rx_idle_en = ~rx_idle_en;
                send_random_item();
            end
        end
        drain_results();
    endtask

    initial begin
        error_count          = 0;
        hold_off_count       = 0;
        tx_idle_en           = 1'b1;
        rx_idle_en           = 1'b1;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_in_valid           = 1'b0;
        i_req_type           = REQ_TICK;
        i_radar_data         = '0;
        i_timepulse_count    = '0;
        i_radar_counter_free = 1'b0;
        i_channel_34_value   = '0;
        i_channel_35_value   = '0;
        model_period         = '0;
        model_countdown      = '0;
        model_word_34        = '0;
        model_word_35        = '0;
        model_frame          = '0;
        model_bits_left      = '0;

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_radar_frame();
        test_downlink_timer();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdrs_pkg.sv
rtl/tdrs_timer.sv
rtl/tdrs_serializer.sv
rtl/telemetry_downlink_and_radar_serializer_core.sv
rtl/tdrs_checker.sv
tb/sv/testbench.sv
